// ----- sv/coo_pkg.sv -----
package coo_pkg;

    localparam int CAPACITY = 256;
    localparam int MAX_DIM  = 1024;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int VAL_W  = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_ZERO = 2'd1;
    localparam t_status ST_FULL = 2'd2;
    localparam t_status ST_OOB  = 2'd3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CAPACITY);

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } t_entry;

endpackage

// ----- sv/coo_if.sv -----
interface coo_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic [coo_pkg::IDX_W-1:0]            row_index;
    logic [coo_pkg::IDX_W-1:0]            column_index;
    logic signed [coo_pkg::VAL_W-1:0]     entry_value;

    modport source (output valid, req_type, row_index, column_index, entry_value,
                    input ready);
    modport sink   (input valid, req_type, row_index, column_index, entry_value,
                    output ready);
endinterface

interface coo_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [coo_pkg::VAL_W-1:0]     read_value;
    coo_pkg::t_status                     status;
    logic [coo_pkg::CNT_W-1:0]            entry_count;

    modport source (output valid, read_value, status, entry_count, input ready);
    modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

interface coo_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [coo_pkg::CFG_IDX_W-1:0]        index;
    logic [coo_pkg::DIM_W-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/coo_sparse_entry_table.sv -----
// Coordinate-list sparse matrix store with room for 256 (row, column, value) entries.
// An insert appends at the next free slot (zero values are skipped, a full table drops
// the item). A lookup checks the position against the row and column counts, then walks
// the stored entries oldest first through the single read port of the entry memory, one
// entry per cycle, and returns the first match or zero. One item is worked on at a time;
// the next is taken once the current result has moved to the output register, which
// holds it until the sink takes it. Every result carries the entry count after the item.
// Config writes are always accepted; unknown indexes are ignored.
module coo_sparse_entry_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    coo_req_if.sink     i_req,
    coo_rsp_if.source   o_rsp,
    coo_cfg_if.sink     i_cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                            r_state, n_state;
    logic [coo_pkg::CNT_W-1:0]             r_count, n_count;
    logic [coo_pkg::CNT_W-1:0]             r_issue, n_issue;
    logic                                  r_rd_vld, n_rd_vld;
    logic signed [coo_pkg::VAL_W-1:0]      r_res_value, n_res_value;
    coo_pkg::t_status                      r_res_status, n_res_status;
    logic                                  r_out_valid, n_out_valid;
    logic signed [coo_pkg::VAL_W-1:0]      r_out_value;
    coo_pkg::t_status                      r_out_status;
    logic [coo_pkg::CNT_W-1:0]             r_out_count;
    logic [coo_pkg::DIM_W-1:0]             r_row_count;
    logic [coo_pkg::DIM_W-1:0]             r_column_count;
    logic [coo_pkg::IDX_W-1:0]             r_req_row;
    logic [coo_pkg::IDX_W-1:0]             r_req_col;

    coo_pkg::t_entry                       r_mem [coo_pkg::CAPACITY];
    coo_pkg::t_entry                       r_rd_data;

    logic w_accept;
    logic w_out_free;
    logic w_wr_en;
    logic w_rd_en;
    logic w_oob;
    logic w_match;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_oob = ({1'b0, i_req.row_index} >= r_row_count) ||
                   ({1'b0, i_req.column_index} >= r_column_count);
    assign w_match = (r_rd_data.row == r_req_row) && (r_rd_data.col == r_req_col);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_issue      = r_issue;
        n_rd_vld     = 1'b0;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_value  = '0;
                    n_res_status = coo_pkg::ST_OK;
                    n_state      = S_DONE;
                    if (i_req.req_type == coo_pkg::REQ_INSERT) begin
                        if (i_req.entry_value == '0) begin
                            n_res_status = coo_pkg::ST_ZERO;
                        end else if (r_count == coo_pkg::CNT_FULL) begin
                            n_res_status = coo_pkg::ST_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        if (w_oob) begin
                            n_res_status = coo_pkg::ST_OOB;
                        end else if (r_count != '0) begin
                            n_state = S_SCAN;
                            n_issue = '0;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_issue < r_count) begin
                    w_rd_en  = 1'b1;
                    n_issue  = r_issue + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    if (w_match) begin
                        // first match wins: drop the reads still in flight
                        n_res_value = r_rd_data.val;
                        n_rd_vld    = 1'b0;
                        n_state     = S_DONE;
                    end else if (r_issue == r_count) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_issue        <= '0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_row_count    <= coo_pkg::DIM_RESET;
            r_column_count <= coo_pkg::DIM_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    coo_pkg::REG_ROW_COUNT:    r_row_count    <= i_cfg.data;
                    coo_pkg::REG_COLUMN_COUNT: r_column_count <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (w_accept) begin
            r_req_row <= i_req.row_index;
            r_req_col <= i_req.column_index;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[coo_pkg::ADDR_W-1:0]] <= '{row: i_req.row_index,
                                                     col: i_req.column_index,
                                                     val: i_req.entry_value};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_issue[coo_pkg::ADDR_W-1:0]];
        end
    end

endmodule

// ----- tb/coo_table_checker.sv -----
module coo_table_checker
    import coo_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    coo_req_if    req_bus,
    coo_rsp_if    rsp_bus,
    coo_cfg_if    cfg_bus,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        t_status                 status;
        logic [CNT_W-1:0]        entry_count;
    } t_table_rsp;

    t_entry           table_entries [CAPACITY];
    logic [CNT_W-1:0] table_fill;
    logic [DIM_W-1:0] row_dim;
    logic [DIM_W-1:0] col_dim;
    t_table_rsp       expected_rsps [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        table_fill   = '0;
        row_dim      = DIM_RESET;
        col_dim      = DIM_RESET;
    end

    function automatic t_table_rsp predict_table_access(
        input logic                    op,
        input logic [IDX_W-1:0]        row,
        input logic [IDX_W-1:0]        col,
        input logic signed [VAL_W-1:0] val
    );
        t_table_rsp rsp;
        logic       hit;
        rsp.read_value = '0;
        rsp.status     = ST_OK;
        hit            = 1'b0;
        if (op == REQ_INSERT) begin
            if (val == 0) begin
                rsp.status = ST_ZERO;
            end else if (table_fill >= CNT_FULL) begin
                rsp.status = ST_FULL;
            end else begin
                table_entries[table_fill[ADDR_W-1:0]] = '{row: row, col: col, val: val};
                table_fill = table_fill + 1'b1;
            end
        end else if (row >= row_dim || col >= col_dim) begin
            rsp.status = ST_OOB;
        end else begin
            // oldest matching entry wins
            for (int i = 0; i < table_fill && !hit; i++) begin
                if (table_entries[i].row == row && table_entries[i].col == col) begin
                    rsp.read_value = table_entries[i].val;
                    hit            = 1'b1;
                end
            end
        end
        rsp.entry_count = table_fill;
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_table_rsp want;
        if (!i_rst_n) begin
            table_fill = '0;
            row_dim    = DIM_RESET;
            col_dim    = DIM_RESET;
            expected_rsps.delete();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                if (cfg_bus.index == REG_ROW_COUNT) begin
                    row_dim = cfg_bus.data;
                end else if (cfg_bus.index == REG_COLUMN_COUNT) begin
                    col_dim = cfg_bus.data;
                end
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result item: read_value %0d status %0d entry_count %0d",
                           rsp_bus.read_value, rsp_bus.status, rsp_bus.entry_count);
                    o_fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_bus.read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0d, got %0d",
                               want.read_value, rsp_bus.read_value);
                        o_fail_count++;
                    end
                    if (rsp_bus.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, rsp_bus.status);
                        o_fail_count++;
                    end
                    if (rsp_bus.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, got %0d",
                               want.entry_count, rsp_bus.entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                expected_rsps.push_back(predict_table_access(req_bus.req_type,
                    req_bus.row_index, req_bus.column_index, req_bus.entry_value));
            end
        end
        o_pending = expected_rsps.size();
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import coo_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int SEGMENTS        = 6;
    localparam int SEGMENT_ITEMS   = 134;
    localparam int DRAIN_CYCLES    = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    coo_req_if req_bus ();
    coo_rsp_if rsp_bus ();
    coo_cfg_if cfg_bus ();

    int fail_count;
    int pending;

    int cycle_count   = 0;
    int send_idle_pct = 18;
    int rcv_idle_pct  = 67;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int cur_rows;
    int cur_cols;
    int insert_count  = 0;
    int lookup_count  = 0;
    int setting_count = 0;
    logic [2*IDX_W-1:0] stored_positions [$];

    int seg_rows [SEGMENTS] = '{1024, 0, 600, 1, 1000, 2047};
    int seg_cols [SEGMENTS] = '{1024, 9, 1024, 700, 1, 2047};

    coo_sparse_entry_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    coo_table_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_bus      (req_bus),
        .rsp_bus      (rsp_bus),
        .cfg_bus      (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when the stimulus asks for one
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = RSP_HOLD_CYCLES;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= op;
        req_bus.row_index    <= row;
        req_bus.column_index <= col;
        req_bus.entry_value  <= val;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
        if (op == REQ_INSERT) begin
            insert_count++;
            if (val != 0) stored_positions.push_back({row, col});
        end else begin
            lookup_count++;
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input int data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= DIM_W'(data);
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
    endtask

    // drop the request, drain every result, then program both bounds and optionally poke the unused index
    task automatic program_dims(input int rows, input int cols, input bit poke_unused);
        req_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        cfg_write(REG_ROW_COUNT, rows);
        cfg_write(REG_COLUMN_COUNT, cols);
        if (poke_unused) cfg_write(REG_UNUSED, 5);
        cfg_bus.valid <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
        setting_count++;
    endtask

    function automatic logic [IDX_W-1:0] near_bound(input int dim);
        int pos;
        pos = dim - int'($urandom_range(1));
        if (pos < 0) pos = 0;
        if (pos > MAX_DIM - 1) pos = MAX_DIM - 1;
        return IDX_W'(pos);
    endfunction

    task automatic send_random_item();
        logic                    op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
        logic [2*IDX_W-1:0]      pos;
        int                      pick;
        op   = ($urandom_range(1) == 0) ? REQ_INSERT : REQ_LOOKUP;
        row  = IDX_W'($urandom);
        col  = IDX_W'($urandom);
        val  = $urandom;
        pick = $urandom_range(99);
        if (op == REQ_INSERT) begin
            if (pick < 10) begin
                val = '0;
            end else if (pick < 18) begin
                case ($urandom_range(3))
                    0:       val = 32'sh7FFFFFFF;
                    1:       val = 32'sh80000000;
                    2:       val = -32'sd1;
                    default: val = 32'sd1;
                endcase
            end
            if (pick >= 18 && pick < 45 && stored_positions.size() > 0) begin
                pos = stored_positions[$urandom_range(stored_positions.size() - 1)];
                {row, col} = pos;
            end else if (pick >= 90) begin
                row = IDX_W'(MAX_DIM - 1);
                col = $urandom_range(1) ? IDX_W'(MAX_DIM - 1) : '0;
            end
        end else begin
            if (pick < 55 && stored_positions.size() > 0) begin
                pos = stored_positions[$urandom_range(stored_positions.size() - 1)];
                {row, col} = pos;
            end else if (pick < 75) begin
                row = near_bound(cur_rows);
                col = near_bound(cur_cols);
            end
        end
        send_item(op, row, col, val);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_INSERT;
        req_bus.row_index    = '0;
        req_bus.column_index = '0;
        req_bus.entry_value  = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_ROW_COUNT;
        cfg_bus.data         = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, zero value, duplicates, bounds
        program_dims(1024, 1024, 1'b0);
        send_item(REQ_LOOKUP, 10'd0, 10'd0, 32'sd0);
        send_item(REQ_INSERT, 10'd0, 10'd0, 32'sh7FFFFFFF);
        send_item(REQ_INSERT, 10'd1023, 10'd1023, 32'sh80000000);
        send_item(REQ_INSERT, 10'd5, 10'd7, 32'sd0);
        send_item(REQ_INSERT, 10'd5, 10'd7, -32'sd1);
        send_item(REQ_INSERT, 10'd5, 10'd7, 32'sd1);
        send_item(REQ_LOOKUP, 10'd5, 10'd7, 32'sh12345678);
        send_item(REQ_LOOKUP, 10'd1023, 10'd1023, 32'sd0);
        send_item(REQ_LOOKUP, 10'd0, 10'd0, 32'sd0);
        send_item(REQ_LOOKUP, 10'd7, 10'd5, 32'sd0);
        send_item(REQ_LOOKUP, 10'd1023, 10'd0, 32'sd0);
        program_dims(1, 1, 1'b0);
        send_item(REQ_LOOKUP, 10'd0, 10'd0, 32'sd0);
        send_item(REQ_LOOKUP, 10'd1, 10'd0, 32'sd0);
        send_item(REQ_LOOKUP, 10'd0, 10'd1, 32'sd0);
        send_item(REQ_INSERT, 10'd900, 10'd900, 32'sd42);
        send_item(REQ_LOOKUP, 10'd900, 10'd900, 32'sd0);
        program_dims(0, 0, 1'b0);
        send_item(REQ_LOOKUP, 10'd0, 10'd0, 32'sd0);
        program_dims(2047, 2047, 1'b1);
        send_item(REQ_LOOKUP, 10'd1023, 10'd1023, 32'sd0);
        send_item(REQ_LOOKUP, 10'd900, 10'd900, 32'sd0);
        send_item(REQ_LOOKUP, 10'd4, 10'd1023, 32'sd0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            program_dims(seg_rows[seg], seg_cols[seg], 1'b0);
            case (seg / 2)
                0: begin
                    send_idle_pct <= 18;
                    rcv_idle_pct  <= 67;
                end
                1: begin
                    send_idle_pct <= 67;
                    rcv_idle_pct  <= 18;
                end
                default: begin
                    send_idle_pct <= 0;
                    rcv_idle_pct  <= 0;
                end
            endcase
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                // starve the output for a while so the block backs up into its input
                if (seg == 0 && n == 40) hold_requests <= hold_requests + 1;
                send_random_item();
            end
        end

        req_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d inserts (%0d nonzero) and %0d lookups under %0d bound settings,",
                 insert_count, stored_positions.size(), lookup_count, setting_count);
        $display("with the table filled past capacity and both channels stalled at random.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- coo_sparse_entry_table.f -----
sv/coo_pkg.sv
sv/coo_if.sv
sv/coo_sparse_entry_table.sv
tb/coo_table_checker.sv
tb/tb.sv
